// ===== sv/rans_pkg.sv =====
// Shared types and constants for the rANS byte encoder.
package rans_pkg;
  localparam int unsigned SCALE_BITS_DEF = 12;
  localparam int unsigned LOWER_BITS_DEF = 23;
  localparam int unsigned FQ_DEPTH = 2;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_ENCODE = 2'd0,
    CMD_SKIP   = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  // Classified command handed from front to back.
  typedef struct packed {
    cmd_e        cmd;
    logic [12:0] freq;
    logic [11:0] start;
  } cmd_t;
endpackage

// ===== sv/rans_front.sv =====
// Front end: table memory, opcode decode, command queue.
module rans_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            opcode_i,
  input  logic [7:0]            symbol_i,
  input  logic [12:0]           frequency_i,
  input  logic [11:0]           cumulative_start_i,
  output logic                  cmd_valid_o,
  output rans_pkg::cmd_t        cmd_o,
  input  logic                  cmd_ready_i
);
  import rans_pkg::*;

  logic [24:0] tbl_mem [256];
  logic [255:0] valid_q;
  logic [24:0] rd_q;
  logic rd_vld_q;
  logic [1:0] rd_op_q;
  logic [7:0] rd_sym_q;
  logic accept;
  cmd_t fq_q [FQ_DEPTH];
  logic [1:0] cnt_q;
  logic rptr_q, wptr_q;
  logic fq_push, fq_pop;
  cmd_t new_cmd;
  logic [12:0] f;

  // stage 1 in flight counts against queue space
  assign full = (cnt_q + {1'b0, rd_vld_q}) >= 2'(FQ_DEPTH);
  assign accept = push && !full;

  always_ff @(posedge clk_i) begin
    if (accept && op_e'(opcode_i) == OP_LOAD) begin
      tbl_mem[symbol_i] <= {frequency_i, cumulative_start_i};
    end
    if (accept) begin
      rd_q <= tbl_mem[symbol_i];
      rd_op_q <= opcode_i;
      rd_sym_q <= symbol_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (accept && op_e'(opcode_i) == OP_LOAD) valid_q[symbol_i] <= 1'b1;
      rd_vld_q <= accept && (op_e'(opcode_i) == OP_ENCODE || op_e'(opcode_i) == OP_FLUSH);
    end
  end

  always_comb begin
    f = valid_q[rd_sym_q] ? rd_q[24:12] : 13'd0;
    new_cmd.freq = f;
    new_cmd.start = valid_q[rd_sym_q] ? rd_q[11:0] : 12'd0;
    if (op_e'(rd_op_q) == OP_FLUSH) new_cmd.cmd = CMD_FLUSH;
    else if (f == 13'd0) new_cmd.cmd = CMD_SKIP;
    else new_cmd.cmd = CMD_ENCODE;
  end

  assign fq_push = rd_vld_q;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o = fq_q[rptr_q];
  assign fq_pop = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (fq_push) fq_q[wptr_q] <= new_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rptr_q <= 1'b0;
      wptr_q <= 1'b0;
    end else begin
      if (fq_push) wptr_q <= ~wptr_q;
      if (fq_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, fq_push} - {1'b0, fq_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(FQ_DEPTH)) else $error("command queue overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !fq_pop) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(FQ_DEPTH) |-> full) else $error("accept while queue full");
endmodule

// ===== sv/rans_back.sv =====
// Back end: renormalize, serial divide, state update, flush, result queue.
module rans_back #(
  parameter int unsigned SCALE_BITS = rans_pkg::SCALE_BITS_DEF,
  parameter int unsigned LOWER_BITS = rans_pkg::LOWER_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  rans_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte_o,
  output logic           status_o,
  output logic           last_o
);
  import rans_pkg::*;

  localparam logic [31:0] LOWER = 32'(64'd1 << LOWER_BITS);
  localparam int unsigned BSH = LOWER_BITS - SCALE_BITS + 8;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RENO = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIN  = 5'b01000,
    S_FLSH = 5'b10000
  } state_e;

  state_e st_q;
  logic [31:0] x_q;
  cmd_t cur_q;
  logic [44:0] bound_q;
  logic [31:0] quo_q;
  logic [12:0] rem_q;
  logic [5:0] bit_q;
  logic [1:0] nb_q;
  logic [13:0] trial;
  logic [31:0] upd;

  // result queue, 4 entries
  logic [9:0] oq_q [4];
  logic [1:0] orp_q, owp_q;
  logic [2:0] ocnt_q;
  logic o_push;
  logic [9:0] o_data;
  logic reno_go;
  logic room;

  function automatic logic cur_skip();
    return cmd_i.cmd == CMD_SKIP;
  endfunction

  assign room = ocnt_q != 3'd4;
  assign reno_go = {13'd0, x_q} >= bound_q;
  assign trial = {rem_q, quo_q[31]};
  assign upd = {quo_q[31-SCALE_BITS:0], {SCALE_BITS{1'b0}}} + {19'd0, rem_q}
               + {20'd0, cur_q.start};
  assign cmd_ready_o = st_q == S_IDLE && room;

  always_comb begin
    o_push = 1'b0;
    o_data = '0;
    case (st_q)
      S_IDLE: begin
        if (cmd_valid_i && room && cur_skip()) begin
          o_push = 1'b1;
          o_data = {8'd0, 1'b1, 1'b1};
        end
      end
      S_RENO: begin
        if (reno_go && room) begin
          o_push = 1'b1;
          o_data = {x_q[7:0] & BYTE_MASK, 1'b0,
                    ({21'd0, x_q[31:8]} < bound_q) || nb_q == 2'd3};
        end
      end
      S_FLSH: begin
        if (room) begin
          o_push = 1'b1;
          o_data = {x_q[7:0], 1'b0, nb_q == 2'd3};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && cmd_valid_i && room) begin
      cur_q <= cmd_i;
      bound_q <= {32'd0, cmd_i.freq} << BSH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      x_q <= LOWER;
      nb_q <= '0;
      bit_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          nb_q <= '0;
          if (cmd_valid_i && room) begin
            if (cmd_i.cmd == CMD_FLUSH) st_q <= S_FLSH;
            else if (cmd_i.cmd == CMD_ENCODE) st_q <= S_RENO;
          end
        end
        S_RENO: begin
          if (reno_go) begin
            if (room) begin
              x_q <= {8'd0, x_q[31:8]};
              nb_q <= nb_q + 2'd1;
            end
          end else begin
            quo_q <= x_q;
            rem_q <= '0;
            bit_q <= '0;
            st_q <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (trial >= {1'b0, cur_q.freq}) begin
            rem_q <= 13'(trial - {1'b0, cur_q.freq});
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= trial[12:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'd31) st_q <= S_FIN;
        end
        S_FIN: begin
          x_q <= upd;
          st_q <= S_IDLE;
        end
        S_FLSH: begin
          if (room) begin
            nb_q <= nb_q + 2'd1;
            if (nb_q == 2'd3) begin
              x_q <= LOWER;
              st_q <= S_IDLE;
            end else begin
              x_q <= {8'd0, x_q[31:8]};
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_push) oq_q[owp_q] <= o_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orp_q <= '0;
      owp_q <= '0;
      ocnt_q <= '0;
    end else begin
      if (o_push) owp_q <= owp_q + 2'd1;
      if (pop && !empty) orp_q <= orp_q + 2'd1;
      ocnt_q <= ocnt_q + {2'd0, o_push} - {2'd0, pop && !empty};
    end
  end

  assign empty = ocnt_q == 3'd0;
  assign out_byte_o = oq_q[orp_q][9:2];
  assign status_o = oq_q[orp_q][1];
  assign last_o = oq_q[orp_q][0];

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= 3'd4) else $error("result queue overflow");
  a_div_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_DIV |-> cur_q.freq != 13'd0) else $error("divide by zero");
endmodule

// ===== sv/rans_byte_encoder.sv =====
// Top level of the byte-wise rANS encoder.
// Usage: items enter through push/full with opcode_i, symbol_i,
// frequency_i and cumulative_start_i. Load (0) writes the 256-entry
// symbol table and gives no result. Encode (1) gives zero to two low
// bytes of the coder state, the final one marked by last_o, or a single
// status_o=1 result when the symbol frequency is zero. Flush (2) gives
// the four state bytes least significant first, last_o on the fourth,
// and returns the state to 2^LOWER_BITS. Opcode 3 is dropped.
// Results leave through empty/pop; a stalled receiver fills the
// four-entry result queue, then the back end halts, the two-entry
// command queue fills, and full rises.
// An encode issues from idle, emits its bytes during renormalization,
// leaves it, runs the bit-serial divider over the 32-bit state and
// writes the state; a skip completes at issue and a flush emits four bytes.
// An accepted transaction passes the table read register before the command queue.
// Reset empties both queues and sets the state to 2^LOWER_BITS; the
// table reads as zero until an entry is loaded.
module rans_byte_encoder #(
  parameter int unsigned SCALE_BITS = rans_pkg::SCALE_BITS_DEF,
  parameter int unsigned LOWER_BITS = rans_pkg::LOWER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  symbol_i,
  input  logic [12:0] frequency_i,
  input  logic [11:0] cumulative_start_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        status_o,
  output logic        last_o
);
  import rans_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  rans_front u_front (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .symbol_i, .frequency_i,
    .cumulative_start_i, .cmd_valid_o(cmd_valid), .cmd_o(cmd),
    .cmd_ready_i(cmd_ready)
  );

  rans_back #(.SCALE_BITS(SCALE_BITS), .LOWER_BITS(LOWER_BITS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_ready_o(cmd_ready), .empty, .pop, .out_byte_o, .status_o, .last_o
  );
endmodule

// ===== tb/rans_byte_encoder_tb.sv =====
// Self-checking testbench for the byte-wise rANS encoder.
module rans_byte_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rans_pkg::*;

  localparam int unsigned SCALE_BITS = 12;
  localparam int unsigned LOWER_BITS = 23;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       skipped;
    logic       tail;
  } enc_out_t;

  int unsigned err_count = 0;

  task automatic report(input string what, input enc_out_t got, input enc_out_t want);
    err_count++;
    $display("mismatch %s: got byte %02h st %0d last %0d, want byte %02h st %0d last %0d",
             what, got.data, got.skipped, got.tail, want.data, want.skipped, want.tail);
  endtask

  class rans_scoreboard;
    logic [31:0] coder_x;
    logic [12:0] freq_mem[256];
    logic [11:0] start_mem[256];
    enc_out_t    pending_q[$];

    function new();
      coder_x = 32'd1 << LOWER_BITS;
      foreach (freq_mem[i]) begin
        freq_mem[i] = '0;
        start_mem[i] = '0;
      end
    endfunction

    function void add_expected(enc_out_t r);
      pending_q = {pending_q, r};
    endfunction

    function void note_item(op_e op, logic [7:0] sym, logic [12:0] fq, logic [11:0] st);
      logic [63:0] bound;
      logic [31:0] x;
      logic [31:0] f;
      int n;
      n = 0;
      case (op)
        OP_LOAD: begin
          freq_mem[sym] = fq;
          start_mem[sym] = st;
        end
        OP_ENCODE: begin
          f = {19'd0, freq_mem[sym]};
          if (f == 0) begin
            add_expected('{8'h00, 1'b1, 1'b1});
          end else begin
            bound = (64'((32'd1 << LOWER_BITS) >> SCALE_BITS) << 8) * 64'(f);
            x = coder_x;
            while (64'(x) >= bound && n < 4) begin
              add_expected('{x[7:0], 1'b0, 1'b0});
              n++;
              x = x >> 8;
            end
            if (n > 0) pending_q[$].tail = 1'b1;
            coder_x = ((x / f) << SCALE_BITS) + (x % f) + {20'd0, start_mem[sym]};
          end
        end
        OP_FLUSH: begin
          for (int i = 0; i < 4; i++)
            add_expected('{coder_x[8*i +: 8], 1'b0, i == 3});
          coder_x = 32'd1 << LOWER_BITS;
        end
        default: ;
      endcase
    endfunction

    task check_result(enc_out_t got);
      enc_out_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result", got, got);
        return;
      end
      want = pending_q.pop_front();
      if (got.data !== want.data) report("out_byte", got, want);
      if (got.skipped !== want.skipped) report("status", got, want);
      if (got.tail !== want.tail) report("last", got, want);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] opcode_i = '0;
  logic [7:0] symbol_i = '0;
  logic [12:0] frequency_i = '0;
  logic [11:0] cumulative_start_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_byte_o;
  logic status_o;
  logic last_o;

  rans_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  logic [7:0] live_syms[$];

  rans_byte_encoder uut (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .symbol_i, .frequency_i,
    .cumulative_start_i, .empty, .pop, .out_byte_o, .status_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one transaction, with a random gap before it.
  task automatic send(input op_e op, input logic [7:0] sym, input logic [12:0] fq,
                      input logic [11:0] st);
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= op;
    symbol_i <= sym;
    frequency_i <= fq;
    cumulative_start_i <= st;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_item(op, sym, fq, st);
  endtask

  task automatic load_entry(input logic [7:0] sym, input logic [12:0] fq,
                            input logic [11:0] st);
    send(OP_LOAD, sym, fq, st);
    if (fq != 0) live_syms = {live_syms, sym};
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // Result side: random pop stalls, check at each accepted transaction.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      if (!empty) sb.check_result('{out_byte_o, status_o, last_o});
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero-frequency symbol, extremes, wide bound, oversize frequency.
    send(OP_ENCODE, 8'd0, '0, '0);
    send(OP_FLUSH, 8'hFF, 13'h1FFF, 12'hFFF);
    load_entry(8'd0, 13'd1, 12'd0);
    load_entry(8'd255, 13'd4096, 12'd4095);
    load_entry(8'd7, 13'h1FFF, 12'd0);
    load_entry(8'd128, 13'd2048, 12'd2048);
    send(OP_ENCODE, 8'd255, '0, '0);
    send(OP_ENCODE, 8'd0, 13'h1FFF, 12'hFFF);
    send(OP_ENCODE, 8'd0, '0, '0);
    send(OP_ENCODE, 8'd7, '0, '0);
    send(OP_NONE, 8'd7, 13'h1555, 12'hAAA);
    send(OP_ENCODE, 8'd128, '0, '0);
    send(OP_ENCODE, 8'd255, '0, '0);
    send(OP_ENCODE, 8'd3, '0, '0);
    send(OP_FLUSH, 8'd0, '0, '0);
    send(OP_ENCODE, 8'd0, '0, '0);
    send(OP_FLUSH, 8'd0, '0, '0);
    drain();

    // Random: mostly encodes of loaded symbols, with reloads, flushes and noise.
    for (int i = 0; i < 210; i++) begin
      r = $urandom_range(0, 99);
      if (i == 100) drain();
      if (r < 12)
        load_entry(8'($urandom), 13'($urandom_range(0, 99) < 10 ?
                   $urandom_range(4097, 8191) : $urandom_range(1, 4096)), 12'($urandom));
      else if (r < 72 && live_syms.size() != 0)
        send(OP_ENCODE, live_syms[$urandom_range(0, live_syms.size() - 1)],
             13'($urandom), 12'($urandom));
      else if (r < 82)
        send(OP_ENCODE, 8'($urandom), 13'($urandom), 12'($urandom));
      else if (r < 90)
        send(OP_FLUSH, 8'($urandom), 13'($urandom), 12'($urandom));
      else if (r < 94)
        load_entry(8'($urandom), 13'd0, 12'($urandom));
      else
        send(OP_NONE, 8'($urandom), 13'($urandom), 12'($urandom));
    end
    send(OP_FLUSH, 8'd0, '0, '0);
    drain();

    if (err_count == 0 && sb.pending_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
